[design/ols_pkg.sv]
// Shared types, widths and codes for the ordered list store.
`default_nettype none

package ols_pkg;

   // list depth and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // beat field widths
   localparam int MODE_W  = 3;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // common width for position vs. fill compares
   localparam int WIDE_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // operation codes
   localparam logic [MODE_W-1:0] MODE_HEAD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TAIL    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DUMP    = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   // one result beat handed from the sequencer to the output register
   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [COUNT_W-1:0]      count;
      logic signed [VAL_W-1:0] element;
      logic                    last;
   } res_type;

endpackage

`default_nettype wire

[design/ordered_list_store_core.sv]
// Top level: bounded ordered list store, element RAM, sequencer, result register.
// Insert shifts the entries above the insert point up one slot and then writes the value,
// delete shifts the entries above the delete point down, reverse swaps pairs through the RAM,
// dump reads each element before its beat; all walk the single element RAM port pair.
// One operation at a time; a new beat is taken as soon as the last result is handed off.
// Reset (synchronous) empties the list; element storage keeps old contents, never read.
`default_nettype none

module ordered_list_store_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ols_pkg::MODE_W-1:0]       req_mode,
   input  wire logic signed [ols_pkg::VAL_W-1:0] req_value,
   input  wire logic [ols_pkg::POS_W-1:0]        req_position,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [ols_pkg::STAT_W-1:0]            rsp_status,
   output logic [ols_pkg::COUNT_W-1:0]           rsp_count,
   output logic signed [ols_pkg::VAL_W-1:0]      rsp_element,
   output logic                                  rsp_last
);

   logic                          ram_wr_en;
   logic [ols_pkg::IDX_W-1:0]     ram_wr_addr;
   logic [ols_pkg::VAL_W-1:0]     ram_wr_data;
   logic                          ram_rd_en;
   logic [ols_pkg::IDX_W-1:0]     ram_rd_addr;
   logic [ols_pkg::VAL_W-1:0]     ram_rd_data;

   logic                          res_valid;
   logic                          res_ready;
   ols_pkg::res_type              res;

   logic                          rsp_valid_ff, rsp_valid_in;
   ols_pkg::res_type              rsp_ff;

   ols_ram #(
      .DEPTH (ols_pkg::CAPACITY),
      .WIDTH (ols_pkg::VAL_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   ols_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_position (req_position),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_ready    (res_ready)
   );

   // result register takes a beat when empty or being drained
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_count   = rsp_ff.count;
   assign rsp_element = rsp_ff.element;
   assign rsp_last    = rsp_ff.last;

endmodule

`default_nettype wire

[design/ols_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module ols_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/ols_ctrl.sv]
// Sequencer: decodes an operation and walks the element RAM to carry it out.
`default_nettype none

module ols_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request side
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ols_pkg::MODE_W-1:0]      req_mode,
   input  wire logic signed [ols_pkg::VAL_W-1:0] req_value,
   input  wire logic [ols_pkg::POS_W-1:0]       req_position,
   // element RAM
   output logic                                 ram_wr_en,
   output logic [ols_pkg::IDX_W-1:0]            ram_wr_addr,
   output logic [ols_pkg::VAL_W-1:0]            ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [ols_pkg::IDX_W-1:0]            ram_rd_addr,
   input  wire logic [ols_pkg::VAL_W-1:0]       ram_rd_data,
   // result beats
   output logic                                 res_valid,
   output ols_pkg::res_type                     res,
   input  wire logic                            res_ready
);

   localparam int CNT_W  = ols_pkg::CNT_W;
   localparam int IDX_W  = ols_pkg::IDX_W;
   localparam int WIDE_W = ols_pkg::WIDE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_SHIFT,
      S_RV_RDLO,
      S_RV_RDHI,
      S_RV_WRLO,
      S_RV_WRHI,
      S_DMP_RD,
      S_DMP_OUT,
      S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [CNT_W-1:0]                walk_ff, walk_in;   // shift target / dump index
   logic                            pend_ff, pend_in;   // RAM read in flight
   logic [IDX_W-1:0]                pos_ff, pos_in;
   logic [ols_pkg::VAL_W-1:0]       val_ff, val_in;
   logic [IDX_W-1:0]                lo_ff, lo_in;
   logic [IDX_W-1:0]                hi_ff, hi_in;
   logic [ols_pkg::VAL_W-1:0]       tmp_ff, tmp_in;
   logic [ols_pkg::STAT_W-1:0]      stat_ff, stat_in;

   logic [CNT_W-1:0]  pos_w;
   logic [WIDE_W-1:0] req_pos_wide;
   logic [WIDE_W-1:0] fill_wide;
   logic [WIDE_W-1:0] eff_pos;
   logic              dump_last;

   assign pos_w        = CNT_W'(pos_ff);
   assign req_pos_wide = WIDE_W'(req_position);
   assign fill_wide    = WIDE_W'(fill_ff);
   assign dump_last    = ((walk_ff + CNT_W'(1)) == fill_ff);
   assign req_stall    = (state_ff != S_IDLE);

   // insert position per mode
   always_comb begin
      case (req_mode)
         ols_pkg::MODE_HEAD: eff_pos = '0;
         ols_pkg::MODE_TAIL: eff_pos = fill_wide;
         default:            eff_pos = req_pos_wide;
      endcase
   end

   // next state and RAM control
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      walk_in     = walk_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      tmp_in      = tmp_ff;
      stat_in     = stat_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      res_valid   = 1'b0;
      res.status  = stat_ff;
      res.count   = ols_pkg::COUNT_W'(fill_ff);
      res.element = '0;
      res.last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               stat_in = ols_pkg::ST_DONE;
               pend_in = 1'b0;
               state_in = S_RESP;
               case (req_mode)
                  ols_pkg::MODE_HEAD, ols_pkg::MODE_TAIL, ols_pkg::MODE_INSERT: begin
                     if (req_mode == ols_pkg::MODE_INSERT && req_pos_wide > fill_wide) begin
                        stat_in = ols_pkg::ST_RANGE;
                     end else if (fill_ff >= ols_pkg::FULL_CNT) begin
                        stat_in = ols_pkg::ST_FULL;
                     end else begin
                        pos_in   = IDX_W'(eff_pos);
                        val_in   = req_value;
                        walk_in  = fill_ff;
                        state_in = S_INS_SHIFT;
                     end
                  end
                  ols_pkg::MODE_DELETE: begin
                     if (fill_ff == '0) begin
                        stat_in = ols_pkg::ST_EMPTY;
                     end else if (req_pos_wide >= fill_wide) begin
                        stat_in = ols_pkg::ST_RANGE;
                     end else begin
                        walk_in  = CNT_W'(req_position);
                        state_in = S_DEL_SHIFT;
                     end
                  end
                  ols_pkg::MODE_REVERSE: begin
                     if (fill_ff >= CNT_W'(2)) begin
                        lo_in    = '0;
                        hi_in    = IDX_W'(fill_ff - CNT_W'(1));
                        state_in = S_RV_RDLO;
                     end
                  end
                  ols_pkg::MODE_DUMP: begin
                     if (fill_ff == '0) begin
                        stat_in = ols_pkg::ST_EMPTY;
                     end else begin
                        walk_in  = '0;
                        state_in = S_DMP_RD;
                     end
                  end
                  default: begin
                     stat_in = ols_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // move entries up one slot, from the tail down to the insert point
         S_INS_SHIFT: begin
            if (!pend_ff) begin
               if (walk_ff > pos_w) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(walk_ff - CNT_W'(1));
                  pend_in     = 1'b1;
               end else begin
                  state_in = S_INS_PUT;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(walk_ff);
               walk_in     = walk_ff - CNT_W'(1);
               if (walk_ff > pos_w + CNT_W'(1)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(walk_ff - CNT_W'(2));
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_INS_PUT;
               end
            end
         end

         S_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = val_ff;
            fill_in     = fill_ff + CNT_W'(1);
            state_in    = S_RESP;
         end

         // move entries down one slot, from the delete point to the tail
         S_DEL_SHIFT: begin
            if (!pend_ff) begin
               if (walk_ff + CNT_W'(1) < fill_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(walk_ff + CNT_W'(1));
                  pend_in     = 1'b1;
               end else begin
                  fill_in  = fill_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(walk_ff);
               walk_in     = walk_ff + CNT_W'(1);
               if (walk_ff + CNT_W'(2) < fill_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(walk_ff + CNT_W'(2));
               end else begin
                  pend_in  = 1'b0;
                  fill_in  = fill_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
            end
         end

         // swap one pair per pass: read lo, read hi, write lo, write hi
         S_RV_RDLO: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = lo_ff;
            state_in    = S_RV_RDHI;
         end

         S_RV_RDHI: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = hi_ff;
            tmp_in      = ram_rd_data;
            state_in    = S_RV_WRLO;
         end

         S_RV_WRLO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff;
            state_in    = S_RV_WRHI;
         end

         S_RV_WRHI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi_ff;
            ram_wr_data = tmp_ff;
            lo_in       = lo_ff + IDX_W'(1);
            hi_in       = hi_ff - IDX_W'(1);
            if (({1'b0, lo_ff} + (IDX_W + 1)'(2)) < {1'b0, hi_ff}) begin
               state_in = S_RV_RDLO;
            end else begin
               state_in = S_RESP;
            end
         end

         // dump: one read, then one beat per element
         S_DMP_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = IDX_W'(walk_ff);
            state_in    = S_DMP_OUT;
         end

         S_DMP_OUT: begin
            res_valid   = 1'b1;
            res.status  = ols_pkg::ST_DONE;
            res.element = ram_rd_data;
            res.last    = dump_last;
            if (res_ready) begin
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  walk_in  = walk_ff + CNT_W'(1);
                  state_in = S_DMP_RD;
               end
            end
         end

         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
      walk_ff <= walk_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      tmp_ff  <= tmp_in;
      stat_ff <= stat_in;
   end

endmodule

`default_nettype wire
